>>> rtl/dh_link_transform_assert.svh
// Assertion macros shared by the link transform RTL.
`ifndef DH_LINK_TRANSFORM_ASSERT_SVH
`define DH_LINK_TRANSFORM_ASSERT_SVH
// An implication checked at every clock edge outside reset.
`define DHL_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// A next-cycle implication.
`define DHL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

>>> rtl/dhl_pkg.sv
// Package of types, constants and tables for the link transform.
package dhl_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ZW = 33;
	localparam int XW = 33;
	localparam logic signed [XW-1:0] GAIN = 33'sd652032874;
	localparam logic signed [ZW-1:0] HALF_PI = 33'sd1686629713;
	localparam logic signed [ZW-1:0] PI = 33'sd3373259426;
	localparam logic signed [XW-1:0] ONE = 33'sd1073741824;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic flip;
	} cordic_t;

	// A lane carries both angles and the pass-through lengths.
	typedef struct packed {
		cordic_t jnt;
		cordic_t tws;
		logic signed [23:0] len;
		logic signed [23:0] offs;
	} lane_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		case (i)
			0: atan_q30 = 33'sd843314857;
			1: atan_q30 = 33'sd497837829;
			2: atan_q30 = 33'sd263043837;
			3: atan_q30 = 33'sd133525159;
			4: atan_q30 = 33'sd67021687;
			5: atan_q30 = 33'sd33543516;
			6: atan_q30 = 33'sd16775851;
			7: atan_q30 = 33'sd8388437;
			8: atan_q30 = 33'sd4194283;
			9: atan_q30 = 33'sd2097149;
			default: atan_q30 = ZW'(33'sd1073741824 >>> i);
		endcase
	endfunction
endpackage

>>> rtl/dhl_cell.sv
// One CORDIC rotation cell for both angles of a lane, with its pipeline register.
module dhl_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  dhl_pkg::lane_t lane_in,
	output logic vld_out,
	output dhl_pkg::lane_t lane_out
);
	function automatic dhl_pkg::cordic_t rot(input dhl_pkg::cordic_t c);
		dhl_pkg::cordic_t r;
		r = c;
		if (!c.z[dhl_pkg::ZW-1]) begin
			r.x = c.x - (c.y >>> STAGE);
			r.y = c.y + (c.x >>> STAGE);
			r.z = c.z - dhl_pkg::atan_q30(STAGE);
		end else begin
			r.x = c.x + (c.y >>> STAGE);
			r.y = c.y - (c.x >>> STAGE);
			r.z = c.z + dhl_pkg::atan_q30(STAGE);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out.jnt <= rot(lane_in.jnt);
			lane_out.tws <= rot(lane_in.tws);
			lane_out.len <= lane_in.len;
			lane_out.offs <= lane_in.offs;
		end
	end
endmodule

>>> rtl/dhl_finish.sv
// Output stages: sign fold, clamps, products and rounding of the transform entries.
module dhl_finish (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  dhl_pkg::lane_t lane_in,
	output logic vld_out,
	output logic [199:0] res
);
	logic signed [31:0] ct, st, ca, sa;
	logic signed [31:0] ct_s1, st_s1, ca_s1, sa_s1;
	logic signed [23:0] len_s1, offs_s1, offs_s2;
	logic signed [63:0] p01_s2, p02_s2, p11_s2, p12_s2;
	logic signed [55:0] px_s2, py_s2;
	logic signed [31:0] ct_s2, st_s2, ca_s2, sa_s2;
	logic vld_s1;

	function automatic logic signed [31:0] fold(input logic signed [dhl_pkg::XW-1:0] v,
			input logic f);
		logic signed [dhl_pkg::XW:0] t;
		t = f ? -{v[dhl_pkg::XW-1], v} : {v[dhl_pkg::XW-1], v};
		if (t > dhl_pkg::ONE) t = dhl_pkg::ONE;
		if (t < -dhl_pkg::ONE) t = -dhl_pkg::ONE;
		return t[31:0];
	endfunction

	function automatic logic [15:0] rnd1(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = (33'(v) + 33'sd32768) >>> 16;
		if (t > 33'sd16384) t = 33'sd16384;
		return t[15:0];
	endfunction

	function automatic logic [15:0] rndp(input logic signed [63:0] p, input logic neg);
		logic signed [64:0] t;
		t = neg ? -65'(p) : 65'(p);
		t = (t + (65'sd1 <<< 45)) >>> 46;
		if (t > 65'sd16384) t = 65'sd16384;
		if (t < -65'sd16384) t = -65'sd16384;
		return t[15:0];
	endfunction

	function automatic logic [23:0] rndq(input logic signed [55:0] p);
		logic signed [56:0] t;
		t = (57'(p) + (57'sd1 <<< 29)) >>> 30;
		if (t > 57'sd8388607) t = 57'sd8388607;
		if (t < -57'sd8388608) t = -57'sd8388608;
		return t[23:0];
	endfunction

	assign ct = fold(lane_in.jnt.x, lane_in.jnt.flip);
	assign st = fold(lane_in.jnt.y, lane_in.jnt.flip);
	assign ca = fold(lane_in.tws.x, lane_in.tws.flip);
	assign sa = fold(lane_in.tws.y, lane_in.tws.flip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ct_s1 <= ct;
			st_s1 <= st;
			ca_s1 <= ca;
			sa_s1 <= sa;
			len_s1 <= lane_in.len;
			offs_s1 <= lane_in.offs;
			p01_s2 <= st_s1 * ca_s1;
			p02_s2 <= st_s1 * sa_s1;
			p11_s2 <= ct_s1 * ca_s1;
			p12_s2 <= ct_s1 * sa_s1;
			px_s2 <= 56'(len_s1) * 56'(ct_s1);
			py_s2 <= 56'(len_s1) * 56'(st_s1);
			ct_s2 <= ct_s1;
			st_s2 <= st_s1;
			ca_s2 <= ca_s1;
			sa_s2 <= sa_s1;
			offs_s2 <= offs_s1;
		end
	end

	assign res = {offs_s2, rnd1(ca_s2), rnd1(sa_s2), rndq(py_s2),
		rndp(p12_s2, 1'b1), rndp(p11_s2, 1'b0), rnd1(st_s2), rndq(px_s2),
		rndp(p02_s2, 1'b0), rndp(p01_s2, 1'b1), rnd1(ct_s2)};
endmodule

>>> rtl/dh_link_transform.sv
// Top level of the Denavit-Hartenberg link transform pipeline.
// One link's parameters are taken per beat, one beat each clock cycle while the
// output beat is not held. The transform passes through one fold register, one
// register per CORDIC cell in the chain, and two output stages for the
// products. The whole chain advances together and holds when the output
// beat is not taken.
`include "dh_link_transform_assert.svh"
module dh_link_transform #(
	parameter int CORDIC_STAGES = dhl_pkg::CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// link_length[23:0], link_twist[39:24], link_offset[63:40], joint_angle[79:64]
	input  logic [79:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y, rot_21,
	// rot_22, pos_z from bit 0 up
	output logic [199:0] m_tdata
);
	localparam int N = (CORDIC_STAGES < dhl_pkg::ATAN_ENTRIES) ? CORDIC_STAGES
		: dhl_pkg::ATAN_ENTRIES;

	logic en;
	logic vld [N+1];
	dhl_pkg::lane_t lane [N+1];

	assign en = m_tready || !m_tvalid;
	assign s_tready = en;

	function automatic dhl_pkg::cordic_t start(input logic signed [15:0] a);
		dhl_pkg::cordic_t c;
		c.x = dhl_pkg::GAIN;
		c.y = '0;
		c.z = dhl_pkg::ZW'(a) <<< 17;
		c.flip = 1'b0;
		if (c.z > dhl_pkg::HALF_PI) begin
			c.z = c.z - dhl_pkg::PI;
			c.flip = 1'b1;
		end else if (c.z < -dhl_pkg::HALF_PI) begin
			c.z = c.z + dhl_pkg::PI;
			c.flip = 1'b1;
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane[0].len <= s_tdata[23:0];
			lane[0].tws <= start(s_tdata[39:24]);
			lane[0].offs <= s_tdata[63:40];
			lane[0].jnt <= start(s_tdata[79:64]);
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		dhl_cell #(.STAGE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld[g]), .lane_in(lane[g]),
			.vld_out(vld[g+1]), .lane_out(lane[g+1])
		);
	end

	dhl_finish u_finish (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld[N]), .lane_in(lane[N]),
		.vld_out(m_tvalid), .res(m_tdata)
	);

	`DHL_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`DHL_ASSERT_IMP(a_rdy, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output")
endmodule
